// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the decimal text converter.
// Depends on nothing; each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- sv/itd_pkg.sv -----
// Package for the signed integer to decimal ASCII converter.
// Widths, character codes and the control struct of the BCD shift unit.
`default_nettype none

package itd_pkg;

    localparam int VALUE_BITS = 32;
    // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
    localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int LEFT_W     = $clog2(DIGITS + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Commands to the BCD shift unit
    typedef struct packed {
        logic load;   // take a fresh magnitude, clear the digits
        logic step;   // one add-3 and shift step
        logic shift;  // drop the top digit, shift digits up
    } t_dab_ctrl;

endpackage

`default_nettype wire

// ----- sv/itd_if.sv -----
// Valid/ready channel interfaces for the decimal text converter.
// Depends on itd_pkg for the value width.
`default_nettype none

interface itd_in_if
    import itd_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/signed_int_to_decimal_ascii_core.sv -----
// Signed integer to decimal ASCII text.
// Input channel i_in carries one signed VALUE_BITS-bit value per request;
// output channel o_out carries one ASCII character per request, with last
// set on the final character of each number. A negative number starts with
// '-', digits follow most significant first without leading zeros, and zero
// gives a single '0'. The most negative value converts exactly.
// Sequence: after a request is taken the BCD shift unit runs one add-3 and
// shift step per magnitude bit, then leading zeros are dropped at one digit a
// cycle, then one character a cycle is loaded into the output register while
// the receiver keeps up. The single BCD unit takes no new request until the
// last character of the previous number has been loaded.
// i_in.ready is high only while no conversion is running; the final
// character may still wait in the output register while the next request
// is taken. A stalled receiver holds the output register and halts the
// character sequence, with no loss. Synchronous active-low reset empties
// the output register and returns the sequencer to idle.
`default_nettype none

`include "assert_macros.svh"

module signed_int_to_decimal_ascii_core
    import itd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    itd_in_if.sink    i_in,
    itd_out_if.source o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SKIP = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [LEFT_W-1:0]     r_left, n_left;
    logic                  r_neg, n_neg;
    logic                  r_ovalid, n_ovalid;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;

    logic                  in_fire;
    logic                  out_load;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            top_digit;
    t_dab_ctrl             dab_ctrl;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_EMIT) && (!r_ovalid || o_out.ready);

    // Two's complement magnitude; the most negative value maps to itself
    assign mag = i_in.value[VALUE_BITS-1] ? (~i_in.value + VALUE_BITS'(1)) : i_in.value;

    itd_dabble u_dabble (
        .i_clk       (i_clk),
        .i_ctrl      (dab_ctrl),
        .i_mag       (mag),
        .o_top_digit (top_digit)
    );

    // Sequencer and output register load
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_neg    = r_neg;
        n_ovalid = r_ovalid;
        n_char   = r_char;
        n_last   = r_last;
        dab_ctrl = '0;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    dab_ctrl.load = 1'b1;
                    n_neg   = i_in.value[VALUE_BITS-1];
                    n_cnt   = CNT_W'(VALUE_BITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                dab_ctrl.step = 1'b1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_left  = LEFT_W'(DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zeros, always keep the units digit
                if (top_digit == 4'd0 && r_left > LEFT_W'(1)) begin
                    dab_ctrl.shift = 1'b1;
                    n_left = r_left - LEFT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_char = CH_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = CH_ZERO + {4'd0, top_digit};
                        n_last = (r_left == LEFT_W'(1));
                        dab_ctrl.shift = 1'b1;
                        n_left = r_left - LEFT_W'(1);
                        if (r_left == LEFT_W'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // Counters and payload
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_left <= n_left;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    // Checks
    `ASSERT_CLK(a_start_conv, in_fire |=> r_state == S_CONV, "request did not start conversion")
    `ASSERT_NEVER(a_conv_cnt, r_state == S_CONV && r_cnt == '0, "conversion counter ran out")
    `ASSERT_NEVER(a_emit_left, r_state == S_EMIT && r_left == '0, "no digits left while emitting")
    `ASSERT_CLK(a_char_code, o_out.valid |-> (o_out.character == CH_MINUS || (o_out.character >= CH_ZERO && o_out.character <= CH_NINE)), "bad character code")

endmodule

`default_nettype wire

// ----- sv/itd_dabble.sv -----
// BCD shift unit: converts a binary magnitude to packed BCD one bit per step
// (add 3 then shift), and shifts digits out from the top. Uses itd_pkg.
`default_nettype none

module itd_dabble
    import itd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire t_dab_ctrl             i_ctrl,
    input  wire logic [VALUE_BITS-1:0] i_mag,
    output logic      [3:0]            o_top_digit
);

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic [BCD_W-1:0]      adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Next state of the shift registers
    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        if (i_ctrl.load) begin
            n_bin = i_mag;
            n_bcd = '0;
        end else if (i_ctrl.step) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
        end else if (i_ctrl.shift) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

`default_nettype wire

// ----- bench/signed_int_to_decimal_ascii_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for signed_int_to_decimal_ascii_core: random and corner-case values
// go in, and each ASCII character out is checked against a predicted decimal text.
// Depends on itd_pkg and the itd_in_if / itd_out_if channel interfaces.

module signed_int_to_decimal_ascii_core_tb;
    import itd_pkg::*;

    localparam int RANDOM_REQUESTS = 240;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AFTER      = 120;

    localparam logic signed [VALUE_BITS-1:0] MOST_NEG = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] MOST_POS = ~MOST_NEG;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_text_char;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Locally held drive values, known from time zero
    logic                         drive_valid = 1'b0;
    logic signed [VALUE_BITS-1:0] drive_value = '0;
    logic                         take_ready  = 1'b0;

    logic in_taken  = 1'b0;
    logic out_taken = 1'b0;

    logic signed [VALUE_BITS-1:0] pending_values [$];
    t_text_char                   text_expected  [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    itd_in_if  in_ch ();
    itd_out_if out_ch ();

    assign in_ch.valid  = drive_valid;
    assign in_ch.value  = drive_value;
    assign out_ch.ready = take_ready;

    signed_int_to_decimal_ascii_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Idle cycles before the next request; zero throughout calm stretches
    function automatic int draw_wait(input bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Decimal text of one value: optional '-', then digits MSD first
    function automatic void queue_decimal_text(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS:0] mag;
        logic [7:0]          digits [$];
        t_text_char          c;
        bit                  neg;
        neg = v[VALUE_BITS-1];
        // one bit wider so the most negative value keeps its magnitude
        mag = neg ? (~{1'b1, v} + 1'b1) : {1'b0, v};
        do begin
            digits.push_front(CH_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (neg) begin
            c.character = CH_MINUS;
            c.last      = 1'b0;
            text_expected.push_back(c);
        end
        foreach (digits[i]) begin
            c.character = digits[i];
            c.last      = (i == digits.size() - 1);
            text_expected.push_back(c);
        end
    endfunction

    // Sender: presents queued values, holding each until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drive_valid <= 1'b0;
        end else if (drive_valid && !in_taken) begin
            // request still waiting
        end else if (gap_left > 0) begin
            gap_left    = gap_left - 1;
            drive_valid <= 1'b0;
        end else if (pending_values.size() != 0) begin
            drive_value <= pending_values.pop_front();
            drive_valid <= 1'b1;
            gap_left    = draw_wait((items_sent / 32) % 4 == 3);
            items_sent  = items_sent + 1;
        end else begin
            drive_valid <= 1'b0;
        end
    end

    // Receiver: random stalls per character, plus one long hold-off
    always @(negedge i_clk) begin
        logic rdy;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (out_taken)
                stall_left = draw_wait((results_seen / 64) % 4 == 2);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                rdy       = 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                rdy        = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            take_ready <= rdy;
        end
    end

    // Monitor: predict on each taken request, check each taken character
    always @(posedge i_clk) begin
        t_text_char want;
        in_taken  <= in_ch.valid && in_ch.ready;
        out_taken <= out_ch.valid && out_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            queue_decimal_text(in_ch.value);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen = results_seen + 1;
            if (text_expected.size() == 0) begin
                $error("character: expected none, got %h (last %b)",
                       out_ch.character, out_ch.last);
                fail_count = fail_count + 1;
            end else begin
                want = text_expected.pop_front();
                if (out_ch.character !== want.character) begin
                    $error("character: expected %h, got %h", want.character, out_ch.character);
                    fail_count = fail_count + 1;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, out_ch.last);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Watchdog on cycles with no request moving on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        logic signed [VALUE_BITS-1:0] v;
        longint lo;
        int     ndig;

        // corner cases: zero, single digits, decade edges, the extremes
        pending_values.push_back(0);
        pending_values.push_back(1);
        pending_values.push_back(-1);
        pending_values.push_back(9);
        pending_values.push_back(-9);
        pending_values.push_back(10);
        pending_values.push_back(-10);
        pending_values.push_back(99);
        pending_values.push_back(100);
        pending_values.push_back(-100);
        pending_values.push_back(12345);
        pending_values.push_back(999999999);
        pending_values.push_back(1000000000);
        pending_values.push_back(-1000000000);
        pending_values.push_back(MOST_POS);
        pending_values.push_back(MOST_POS - 1);
        pending_values.push_back(MOST_NEG);
        pending_values.push_back(MOST_NEG + 1);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);

        repeat (RANDOM_REQUESTS) begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: begin
                    v = $urandom_range(0, 99);
                    if ($urandom_range(0, 1)) v = -v;
                end
                2: begin
                    ndig = $urandom_range(1, 9);
                    lo   = 1;
                    repeat (ndig - 1) lo = lo * 10;
                    v = VALUE_BITS'(lo + $urandom_range(0, 32'(9 * lo - 1)));
                    if ($urandom_range(0, 1)) v = -v;
                end
                default: begin
                    if ($urandom_range(0, 1))
                        v = MOST_POS - $urandom_range(0, 20);
                    else
                        v = MOST_NEG + $urandom_range(0, 20);
                end
            endcase
            pending_values.push_back(v);
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_values.size() != 0 || drive_valid || text_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- signed_int_to_decimal_ascii_core.f -----
+incdir+sv
sv/itd_pkg.sv
sv/itd_if.sv
sv/itd_dabble.sv
sv/signed_int_to_decimal_ascii_core.sv
bench/signed_int_to_decimal_ascii_core_tb.sv
